[design/scba_pkg.sv]
// scba_pkg: shared constants, types and address helpers of the size class bitmap allocator
// used by scba_map, scba_seq and size_class_bitmap_allocator_top; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package scba_pkg;

  localparam int NUM_CLASSES         = 8;
  localparam int MIN_BLOCK_LOG2      = 4;
  localparam int BLOCKS_PER_CLASS    = 256;
  localparam int MAP_WORDS_PER_CLASS = 8;

  localparam int CLS_W   = $clog2(NUM_CLASSES);
  localparam int WORD_W  = $clog2(MAP_WORDS_PER_CLASS);
  localparam int IDX_W   = WORD_W + 5;
  localparam int MAP_AW  = CLS_W + WORD_W;
  localparam int SPAN    = (1 << MIN_BLOCK_LOG2) * BLOCKS_PER_CLASS;
  localparam int SHIFT_W = $clog2(MIN_BLOCK_LOG2 + NUM_CLASSES);

  localparam logic [CLS_W-1:0]  LAST_CLASS = CLS_W'(NUM_CLASSES - 1);
  localparam logic [WORD_W-1:0] LAST_WORD  = WORD_W'(MAP_WORDS_PER_CLASS - 1);

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_FREED     = 3'd1,
    ST_ZERO_SIZE = 3'd2,
    ST_TOO_LARGE = 3'd3,
    ST_ALL_FULL  = 3'd4,
    ST_UNMATCHED = 3'd5
  } scba_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ALLOC_EVAL,
    S_FREE_SCAN,
    S_FREE_WRITE,
    S_ADDR,
    S_DONE
  } scba_state_e;

  typedef struct packed {
    logic              rd_en;
    logic [MAP_AW-1:0] rd_addr;
    logic              wr_en;
    logic [MAP_AW-1:0] wr_addr;
    logic [31:0]       wr_data;
  } scba_map_req_t;

  // byte offset of a class region from the region base, modulo 2^32
  function automatic logic [31:0] class_off(input logic [CLS_W-1:0] c);
    logic [63:0] t;
    t = (64'(SPAN) << c) - 64'(SPAN);
    return t[31:0];
  endfunction

  // bytes spanned by the region of one class
  function automatic logic [32:0] class_span(input logic [CLS_W-1:0] c);
    logic [63:0] t;
    t = 64'(SPAN) << c;
    return t[32:0];
  endfunction

  function automatic logic [32:0] block_bytes(input logic [CLS_W-1:0] c);
    logic [63:0] t;
    t = (64'd1 << MIN_BLOCK_LOG2) << c;
    return t[32:0];
  endfunction

endpackage

`default_nettype wire

[design/scba_map.sv]
// scba_map: used-block bitmap store, one 32-bit word per map row, registered read
// per-row valid bits make never-written rows read as zero; depends on scba_pkg
`timescale 1ns / 1ps
`default_nettype none

module scba_map
  import scba_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire scba_map_req_t req_i,
  output logic [31:0]        rd_data_o
);

  localparam int DEPTH = NUM_CLASSES * MAP_WORDS_PER_CLASS;

  logic [31:0]      mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [31:0]      rdata_q;
  logic             rvalid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rvalid_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rvalid_q ? rdata_q : 32'd0;

endmodule

`default_nettype wire

[design/scba_seq.sv]
// scba_seq: sequencer that scans bitmap words for allocations and region classes for frees,
// one word or one class per cycle, with the output register; depends on scba_pkg
`timescale 1ns / 1ps
`default_nettype none

module scba_seq
  import scba_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic          action_i,
  input  wire logic [31:0]   request_size_i,
  input  wire logic [31:0]   free_address_i,
  input  wire logic [31:0]   region_base_i,
  output scba_map_req_t      map_req_o,
  input  wire logic [31:0]   map_rdata_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [2:0]         status_o,
  output logic [31:0]        block_address_o,
  output logic [2:0]         size_class_o,
  output logic [7:0]         block_index_o
);

  scba_state_e state_q, state_d;

  logic [31:0]       size_q, addr_q;
  logic [CLS_W-1:0]  cls_q, cls_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic [31:0]       cstart_q, cstart_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  scba_status_e      res_st_q, res_st_d;
  logic [31:0]       res_addr_q, res_addr_d;

  logic              out_valid_q;
  logic [2:0]        out_st_q, out_cls_q;
  logic [31:0]       out_addr_q;
  logic [7:0]        out_idx_q;

  logic              accept;
  logic              out_free;

  // size decode
  logic [CLS_W-1:0]  first_cls;
  logic              too_large;

  // allocation word evaluation
  logic [4:0]        zero_pos;
  logic              word_full;
  logic [IDX_W-1:0]  alloc_idx;
  logic              alloc_hit;
  logic              last_word;

  // free class match
  logic [31:0]       delta;
  logic [SHIFT_W-1:0] blk_shift;
  logic [31:0]       delta_idx;
  logic              free_hit;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    first_cls = LAST_CLASS;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (block_bytes(CLS_W'(c)) >= {1'b0, size_q}) begin
        first_cls = CLS_W'(c);
      end
    end
    too_large = {1'b0, size_q} > block_bytes(LAST_CLASS);
  end

  always_comb begin
    zero_pos = 5'd0;
    for (int b = 31; b >= 0; b--) begin
      if (!map_rdata_i[b]) begin
        zero_pos = 5'(b);
      end
    end
    word_full = (map_rdata_i == 32'hFFFF_FFFF);
    alloc_idx = {word_q, zero_pos};
    alloc_hit = !word_full && ({1'b0, alloc_idx} < (IDX_W + 1)'(BLOCKS_PER_CLASS));
    last_word = (cls_q == LAST_CLASS) && (word_q == LAST_WORD);
  end

  assign blk_shift = SHIFT_W'(MIN_BLOCK_LOG2) + SHIFT_W'(cls_q);
  assign delta     = addr_q - cstart_q;
  assign delta_idx = delta >> blk_shift;
  assign free_hit  = {1'b0, delta} < class_span(cls_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (action_i == ACT_FREE) ? S_FREE_SCAN : S_CHECK;
        end
      end
      S_CHECK: begin
        if (size_q == 32'd0 || too_large) begin
          state_d = S_DONE;
        end else begin
          state_d = S_ALLOC_EVAL;
        end
      end
      S_ALLOC_EVAL: begin
        if (alloc_hit) begin
          state_d = S_ADDR;
        end else if (last_word) begin
          state_d = S_DONE;
        end
      end
      S_FREE_SCAN: begin
        if (free_hit) begin
          state_d = S_FREE_WRITE;
        end else if (cls_q == LAST_CLASS) begin
          state_d = S_DONE;
        end
      end
      S_FREE_WRITE: state_d = S_ADDR;
      S_ADDR:       state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and map requests
  always_comb begin
    cls_d      = cls_q;
    word_d     = word_q;
    cstart_d   = cstart_q;
    idx_d      = idx_q;
    res_st_d   = res_st_q;
    res_addr_d = res_addr_q;
    map_req_o  = '0;
    unique case (state_q)
      S_IDLE: begin
        cls_d      = '0;
        word_d     = '0;
        idx_d      = '0;
        cstart_d   = region_base_i;
        res_addr_d = 32'd0;
      end
      S_CHECK: begin
        if (size_q == 32'd0) begin
          res_st_d = ST_ZERO_SIZE;
        end else if (too_large) begin
          res_st_d = ST_TOO_LARGE;
        end else begin
          cls_d             = first_cls;
          cstart_d          = region_base_i + class_off(first_cls);
          map_req_o.rd_en   = 1'b1;
          map_req_o.rd_addr = {first_cls, {WORD_W{1'b0}}};
        end
      end
      S_ALLOC_EVAL: begin
        if (alloc_hit) begin
          idx_d             = alloc_idx;
          res_st_d          = ST_ALLOCATED;
          map_req_o.wr_en   = 1'b1;
          map_req_o.wr_addr = {cls_q, word_q};
          map_req_o.wr_data = map_rdata_i | (32'd1 << zero_pos);
        end else if (last_word) begin
          res_st_d = ST_ALL_FULL;
          cls_d    = '0;
        end else begin
          // next word, spilling into the next class after the last word
          if (word_q == LAST_WORD) begin
            cls_d    = cls_q + 1'b1;
            word_d   = '0;
            cstart_d = region_base_i + class_off(cls_q + 1'b1);
          end else begin
            word_d = word_q + 1'b1;
          end
          map_req_o.rd_en   = 1'b1;
          map_req_o.rd_addr = {cls_d, word_d};
        end
      end
      S_FREE_SCAN: begin
        if (free_hit) begin
          idx_d             = delta_idx[IDX_W-1:0];
          res_st_d          = ST_FREED;
          map_req_o.rd_en   = 1'b1;
          map_req_o.rd_addr = {cls_q, delta_idx[IDX_W-1:5]};
        end else if (cls_q == LAST_CLASS) begin
          res_st_d = ST_UNMATCHED;
          cls_d    = '0;
        end else begin
          cls_d    = cls_q + 1'b1;
          cstart_d = region_base_i + class_off(cls_q + 1'b1);
        end
      end
      S_FREE_WRITE: begin
        map_req_o.wr_en   = 1'b1;
        map_req_o.wr_addr = {cls_q, idx_q[IDX_W-1:5]};
        map_req_o.wr_data = map_rdata_i & ~(32'd1 << idx_q[4:0]);
      end
      S_ADDR: begin
        res_addr_d = cstart_q + (32'(idx_q) << blk_shift);
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      size_q <= request_size_i;
      addr_q <= free_address_i;
    end
    cls_q      <= cls_d;
    word_q     <= word_d;
    cstart_q   <= cstart_d;
    idx_q      <= idx_d;
    res_st_q   <= res_st_d;
    res_addr_q <= res_addr_d;
    if (state_q == S_DONE && out_free) begin
      out_st_q   <= res_st_q;
      out_addr_q <= res_addr_q;
      out_cls_q  <= 3'(cls_q);
      out_idx_q  <= 8'(idx_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_st_q;
  assign block_address_o = out_addr_q;
  assign size_class_o    = out_cls_q;
  assign block_index_o   = out_idx_q;

endmodule

`default_nettype wire

[design/size_class_bitmap_allocator_top.sv]
// size_class_bitmap_allocator_top: power-of-two size class allocator, region base register,
// sequencer and bitmap store; depends on scba_pkg, scba_map and scba_seq
//
// Usage: an item on the input channel (in_valid_i/in_stall_o) either allocates a block of
// request_size_i bytes (action 0) or frees the block holding free_address_i (action 1).
// Exactly one result leaves on the output channel (out_valid_o/out_stall_i) per item:
// status, block address, size class and block index.
// The region base is written through cfg_valid_i/cfg_ready_o/cfg_data_i; the user must
// do so only while idle, the block does not enforce it. Throughput: one item at a time;
// in_stall_o is high from the transfer until the result is placed in the output register.
// An allocation scans bitmap words one at a time over the shared single-word map read port
// (1 to 64 words) and reports all full once every class from the fitting one up is full;
// a free checks region classes in order (1 to 8); zero or oversize requests read no word.
// A waiting result sits in the output register while the next item is worked on; when the
// receiver stalls and the register is still full, the next result is held back.
// Reset clears the region base to 0 and marks every block free at once through per-row
// valid bits, so items are taken from the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module size_class_bitmap_allocator_top
  import scba_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        action_i,
  input  wire logic [31:0] request_size_i,
  input  wire logic [31:0] free_address_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [31:0]      block_address_o,
  output logic [2:0]       size_class_o,
  output logic [7:0]       block_index_o
);

  logic [31:0]   region_base_q;
  scba_map_req_t map_req;
  logic [31:0]   map_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_base_q <= 32'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      region_base_q <= cfg_data_i;
    end
  end

  scba_map u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (map_req),
    .rd_data_o (map_rdata)
  );

  scba_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .request_size_i  (request_size_i),
    .free_address_i  (free_address_i),
    .region_base_i   (region_base_q),
    .map_req_o       (map_req),
    .map_rdata_i     (map_rdata),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .block_address_o (block_address_o),
    .size_class_o    (size_class_o),
    .block_index_o   (block_index_o)
  );

endmodule

`default_nettype wire

[bench/tb_size_class_bitmap_allocator_top.sv]
// tb_size_class_bitmap_allocator_top: self-checking bench for the size class bitmap allocator,
// a directed table then random allocate/free traffic checked against a shadow bitmap
// depends on scba_pkg and size_class_bitmap_allocator_top
`timescale 1ns / 1ps

module tb_size_class_bitmap_allocator_top;
  import scba_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int MAP_DEPTH       = NUM_CLASSES * MAP_WORDS_PER_CLASS;
  localparam int NUM_DIRECTED    = 25;
  localparam int MISMATCH_PRINTS = 10;
  localparam int SETTLE_CYCLES   = 80;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] addr;
    logic [2:0]  cls;
    logic [7:0]  idx;
  } alloc_result_t;

  typedef struct packed {
    logic [2:0] cls;
    logic [7:0] idx;
  } block_slot_t;

  typedef struct packed {
    logic        act;
    logic [31:0] size;
    logic [31:0] addr;
    logic        typed;
    logic [2:0]  st;
    logic [31:0] baddr;
    logic [2:0]  cls;
    logic [7:0]  idx;
  } directed_row_t;

  // base is 0 and every block free when this table starts
  localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{ACT_ALLOC, 32'd0,          32'hFFFF_FFFF, 1'b1, ST_ZERO_SIZE, 32'h0,     3'd0, 8'd0},
    '{ACT_ALLOC, 32'hFFFF_FFFF,  32'h0,         1'b1, ST_TOO_LARGE, 32'h0,     3'd0, 8'd0},
    '{ACT_ALLOC, 32'd2049,       32'h1234_5678, 1'b1, ST_TOO_LARGE, 32'h0,     3'd0, 8'd0},
    '{ACT_ALLOC, 32'd1,          32'h0,         1'b1, ST_ALLOCATED, 32'h0,     3'd0, 8'd0},
    '{ACT_ALLOC, 32'd16,         32'h0,         1'b1, ST_ALLOCATED, 32'h10,    3'd0, 8'd1},
    '{ACT_ALLOC, 32'd17,         32'h0,         1'b1, ST_ALLOCATED, 32'h1000,  3'd1, 8'd0},
    '{ACT_ALLOC, 32'd2048,       32'h0,         1'b1, ST_ALLOCATED, 32'h7F000, 3'd7, 8'd0},
    '{ACT_ALLOC, 32'd1025,       32'h0,         1'b1, ST_ALLOCATED, 32'h7F800, 3'd7, 8'd1},
    '{ACT_FREE,  32'hFFFF_FFFF,  32'h1005,      1'b1, ST_FREED,     32'h1000,  3'd1, 8'd0},
    '{ACT_FREE,  32'd0,          32'h1000,      1'b1, ST_FREED,     32'h1000,  3'd1, 8'd0},
    '{ACT_FREE,  32'd0,          32'hFF000,     1'b1, ST_UNMATCHED, 32'h0,     3'd0, 8'd0},
    '{ACT_FREE,  32'hFFFF_FFFF,  32'hFFFF_FFFF, 1'b1, ST_UNMATCHED, 32'h0,     3'd0, 8'd0},
    '{ACT_FREE,  32'd0,          32'hFEFFF,     1'b1, ST_FREED,     32'hFE800, 3'd7, 8'd255},
    '{ACT_FREE,  32'd0,          32'h0,         1'b1, ST_FREED,     32'h0,     3'd0, 8'd0},
    '{ACT_ALLOC, 32'd5,          32'h0,         1'b1, ST_ALLOCATED, 32'h0,     3'd0, 8'd0},
    '{ACT_ALLOC, 32'd32,         32'h0,         1'b0, ST_ALLOCATED, 32'h0,     3'd0, 8'd0},
    '{ACT_ALLOC, 32'd33,         32'h0,         1'b0, ST_ALLOCATED, 32'h0,     3'd0, 8'd0},
    '{ACT_ALLOC, 32'd64,         32'h0,         1'b0, ST_ALLOCATED, 32'h0,     3'd0, 8'd0},
    '{ACT_ALLOC, 32'd65,         32'h0,         1'b0, ST_ALLOCATED, 32'h0,     3'd0, 8'd0},
    '{ACT_ALLOC, 32'd128,        32'h0,         1'b0, ST_ALLOCATED, 32'h0,     3'd0, 8'd0},
    '{ACT_ALLOC, 32'd256,        32'h0,         1'b0, ST_ALLOCATED, 32'h0,     3'd0, 8'd0},
    '{ACT_ALLOC, 32'd512,        32'h0,         1'b0, ST_ALLOCATED, 32'h0,     3'd0, 8'd0},
    '{ACT_ALLOC, 32'd1024,       32'h0,         1'b0, ST_ALLOCATED, 32'h0,     3'd0, 8'd0},
    '{ACT_FREE,  32'd0,          32'h3000,      1'b0, ST_ALLOCATED, 32'h0,     3'd0, 8'd0},
    '{ACT_FREE,  32'd0,          32'h0FFF,      1'b0, ST_ALLOCATED, 32'h0,     3'd0, 8'd0}
  };

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i     = '0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic        action_i       = ACT_ALLOC;
  logic [31:0] request_size_i = '0;
  logic [31:0] free_address_i = '0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [2:0]  status_o;
  logic [31:0] block_address_o;
  logic [2:0]  size_class_o;
  logic [7:0]  block_index_o;

  logic [31:0]   shadow_base;
  logic [31:0]   shadow_used_map [MAP_DEPTH];
  alloc_result_t awaited_results [$];
  block_slot_t   live_blocks [$];
  alloc_result_t oldest_result;
  int            mismatch_count = 0;
  int            cycle_count    = 0;
  int            tx_idle_pct    = 0;
  int            rx_stall_pct   = 0;

  always #5 clk_i = ~clk_i;

  size_class_bitmap_allocator_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .request_size_i (request_size_i),
    .free_address_i (free_address_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .block_address_o(block_address_o),
    .size_class_o   (size_class_o),
    .block_index_o  (block_index_o)
  );

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               awaited_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MISMATCH_PRINTS)
          $display("unexpected result: status %0d addr %h class %0d index %0d",
                   status_o, block_address_o, size_class_o, block_index_o);
      end else begin
        oldest_result = awaited_results.pop_front();
        if (status_o !== oldest_result.status || block_address_o !== oldest_result.addr ||
            size_class_o !== oldest_result.cls || block_index_o !== oldest_result.idx) begin
          mismatch_count++;
          if (mismatch_count <= MISMATCH_PRINTS)
            $display("mismatch: exp status %0d addr %h class %0d index %0d, got %0d %h %0d %0d",
                     oldest_result.status, oldest_result.addr, oldest_result.cls,
                     oldest_result.idx, status_o, block_address_o, size_class_o,
                     block_index_o);
        end
      end
    end
  end

  function automatic logic [63:0] class_block_size(int c);
    return 64'd1 << (MIN_BLOCK_LOG2 + c);
  endfunction

  function automatic logic [31:0] region_start(int c);
    logic [63:0] off;
    off = (64'd1 << MIN_BLOCK_LOG2) * 64'(BLOCKS_PER_CLASS) * ((64'd1 << c) - 64'd1);
    return shadow_base + off[31:0];
  endfunction

  function automatic logic [31:0] block_start(int c, int i);
    logic [63:0] off;
    off = class_block_size(c) * 64'(i);
    return region_start(c) + off[31:0];
  endfunction

  // works out the result of one request and applies it to the shadow bitmap
  function automatic alloc_result_t apply_request(logic act, logic [31:0] size,
                                                  logic [31:0] addr);
    alloc_result_t r;
    int            c;
    int            first;
    int            w;
    int            b;
    int            wi;
    logic [31:0]   delta;
    logic [63:0]   idx;
    bit            done;
    r    = '0;
    done = 1'b0;
    if (act == ACT_ALLOC) begin
      if (size == 32'd0) begin
        r.status = ST_ZERO_SIZE;
      end else if (64'(size) > class_block_size(NUM_CLASSES - 1)) begin
        r.status = ST_TOO_LARGE;
      end else begin
        first = 0;
        while (class_block_size(first) < 64'(size)) first++;
        r.status = ST_ALL_FULL;
        // lowest free block, spilling into larger classes
        for (c = first; c < NUM_CLASSES && !done; c++)
          for (w = 0; w < MAP_WORDS_PER_CLASS && !done; w++)
            for (b = 0; b < 32 && !done; b++)
              if (w * 32 + b < BLOCKS_PER_CLASS &&
                  !shadow_used_map[c * MAP_WORDS_PER_CLASS + w][b]) begin
                shadow_used_map[c * MAP_WORDS_PER_CLASS + w][b] = 1'b1;
                r.status = ST_ALLOCATED;
                r.addr   = block_start(c, w * 32 + b);
                r.cls    = 3'(c);
                r.idx    = 8'(w * 32 + b);
                done     = 1'b1;
              end
      end
    end else begin
      r.status = ST_UNMATCHED;
      for (c = 0; c < NUM_CLASSES && !done; c++) begin
        delta = addr - region_start(c);
        idx   = 64'(delta) / class_block_size(c);
        if (idx < 64'(BLOCKS_PER_CLASS)) begin
          wi = int'(idx >> 5);
          if (wi < MAP_WORDS_PER_CLASS)
            shadow_used_map[c * MAP_WORDS_PER_CLASS + wi][idx[4:0]] = 1'b0;
          r.status = ST_FREED;
          r.addr   = block_start(c, int'(idx));
          r.cls    = 3'(c);
          r.idx    = 8'(idx);
          done     = 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic issue_request(input logic act, input logic [31:0] size,
                               input logic [31:0] addr, input logic typed,
                               input alloc_result_t typed_res, output alloc_result_t res);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    request_size_i <= size;
    free_address_i <= addr;
    do @(posedge clk_i); while (in_stall_o);
    res = apply_request(act, size, addr);
    awaited_results.push_back(typed ? typed_res : res);
    if (res.status == ST_ALLOCATED) live_blocks.push_back('{res.cls, res.idx});
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  task automatic write_region_base(input logic [31:0] value);
    wait_for_drain();
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    shadow_base  = value;
  endtask

  // free a block still held, at a random byte inside it
  task automatic free_live_block();
    int            n;
    block_slot_t   s;
    alloc_result_t r;
    n = $urandom_range(live_blocks.size() - 1);
    s = live_blocks[n];
    live_blocks.delete(n);
    issue_request(ACT_FREE, $urandom,
                  block_start(s.cls, s.idx) + $urandom_range(32'(class_block_size(s.cls)) - 1),
                  1'b0, '0, r);
  endtask

  task automatic run_mixed(input int count, input int drain_at);
    int            pick;
    int            k;
    logic [31:0]   size;
    logic [31:0]   addr;
    alloc_result_t r;
    for (int i = 0; i < count; i++) begin
      if (i == drain_at) wait_for_drain();
      pick = $urandom_range(99);
      k    = $urandom_range(NUM_CLASSES - 1);
      if (pick >= 52 && pick < 85 && live_blocks.size() != 0) begin
        free_live_block();
      end else if (pick < 85) begin
        if (pick >= 45 && pick < 52)
          size = $urandom_range(1) ? 32'd0 : $urandom_range(32'hFFFF_FFFF, 2049);
        else if (k == 0)
          size = $urandom_range(1 << MIN_BLOCK_LOG2, 1);
        else
          size = $urandom_range(1 << (MIN_BLOCK_LOG2 + k), (1 << (MIN_BLOCK_LOG2 + k - 1)) + 1);
        issue_request(ACT_ALLOC, size, $urandom, 1'b0, '0, r);
      end else if (pick < 93) begin
        // anywhere, or inside a region up to and including its far edge
        addr = $urandom_range(1) ? $urandom :
               region_start(k) + $urandom_range(32'(class_block_size(k)) * BLOCKS_PER_CLASS);
        issue_request(ACT_FREE, $urandom, addr, 1'b0, '0, r);
      end else begin
        // whole block of any class, usually already free
        addr = block_start(k, $urandom_range(BLOCKS_PER_CLASS - 1));
        issue_request(ACT_FREE, $urandom, addr, 1'b0, '0, r);
      end
    end
  endtask

  initial begin
    alloc_result_t r;
    int            full_count;
    int            n;
    shadow_base = '0;
    foreach (shadow_used_map[i]) shadow_used_map[i] = '0;
    tx_idle_pct   = 12;
    rx_stall_pct <= 77;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++)
      issue_request(DIRECTED_ROWS[i].act, DIRECTED_ROWS[i].size, DIRECTED_ROWS[i].addr,
                    DIRECTED_ROWS[i].typed,
                    '{DIRECTED_ROWS[i].st, DIRECTED_ROWS[i].baddr, DIRECTED_ROWS[i].cls,
                      DIRECTED_ROWS[i].idx}, r);

    // base at the top of the address space, so class regions wrap
    write_region_base(32'hFFFF_FFFF);
    run_mixed(150, 75);

    // fill the two largest classes until allocations are refused, then free half of all blocks held
    tx_idle_pct   = 77;
    rx_stall_pct <= 12;
    write_region_base($urandom);
    full_count = 0;
    while (full_count < 6) begin
      issue_request(ACT_ALLOC, $urandom_range(2048, 513), $urandom, 1'b0, '0, r);
      if (r.status == ST_ALL_FULL) full_count++;
    end
    n = live_blocks.size() / 2;
    repeat (n) free_live_block();

    tx_idle_pct   = 0;
    rx_stall_pct <= 0;
    write_region_base(32'hFFF8_0000);
    run_mixed(150, -1);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

[files.f]
design/scba_pkg.sv
design/scba_map.sv
design/scba_seq.sv
design/size_class_bitmap_allocator_top.sv
bench/tb_size_class_bitmap_allocator_top.sv
